FILE: rtl/sorted_set_insert_delete_core_assert.svh
// assertion macros for the sorted set core
// no dependencies; included by the top level only
`ifndef SORTED_SET_INSERT_DELETE_CORE_ASSERT_SVH
`define SORTED_SET_INSERT_DELETE_CORE_ASSERT_SVH

// same-cycle implication
`define SSID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted set check failed");

// next-cycle implication
`define SSID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted set check failed");

`endif

FILE: rtl/ssid_pkg.sv
// shared types and constants for the sorted set core
// no dependencies
`timescale 1ns / 1ps

package ssid_pkg;

    localparam int CAPACITY     = 32;
    localparam int FEATURE_BITS = 16;
    localparam int FEAT_W       = 16;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int IDX_W        = $clog2(CAPACITY);
    localparam int OUT_CNT_W    = 6;

    localparam int IN_TDATA_W   = 16;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_TUSER_W  = 3;

    localparam logic [FEAT_W-1:0] FEAT_MASK = FEAT_W'((64'd1 << FEATURE_BITS) - 64'd1);

    typedef enum logic [1:0] {
        FN_ADD  = 2'd0,
        FN_DEL  = 2'd1,
        FN_LIST = 2'd2,
        FN_NONE = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_EMPTY   = 3'd4
    } t_status;

endpackage

FILE: rtl/sorted_set_insert_delete_core.sv
// A request is held in the request register; its result goes to the result register once the output is free.
// Throughput: one add or delete per cycle while the output is not stalled; a listing holds
// the request register until its last result is emitted, one member per cycle read from the cell row.
// All cells compare against the feature in parallel, so an add or delete is one pass.
// Reset: synchronous, active low; clears member count, list index and valid flags, cells keep contents.
// file: top level of the sorted set core, depends on ssid_pkg and the assert header
`timescale 1ns / 1ps
`include "sorted_set_insert_delete_core_assert.svh"

module sorted_set_insert_delete_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssid_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // feature[15:0]
    input  logic [ssid_pkg::IN_TUSER_W-1:0]    s_axis_tuser,   // func[1:0]
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssid_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,   // count[5:0], member[21:6], zero pad
    output logic [ssid_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,   // status[2:0]
    output logic                               m_axis_tlast
);

    import ssid_pkg::*;

    // request register
    logic              r_in_valid;
    t_func             r_func;
    logic [FEAT_W-1:0] r_feat;

    // set state
    logic [FEAT_W-1:0] r_cells [CAPACITY];
    logic [FEAT_W-1:0] n_cells [CAPACITY];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [IDX_W-1:0]  r_idx;

    // result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [CNT_W-1:0]  r_out_count;
    logic [FEAT_W-1:0] r_out_member;
    logic              r_out_last;

    t_status           n_status;
    logic [FEAT_W-1:0] n_member;
    logic              n_last;
    logic              n_emit;

    logic [FEAT_W-1:0] feat_m;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic              found;
    logic              full;
    logic              out_free;
    logic              proc;
    logic              list_more;
    logic              in_done;

    assign feat_m    = r_feat & FEAT_MASK;
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign out_free  = !r_out_valid || m_axis_tready;
    assign proc      = r_in_valid && out_free;
    assign list_more = (r_func == FN_LIST) && (r_count != '0)
                       && (CNT_W'(r_idx) != (r_count - CNT_W'(1)));
    assign in_done   = proc && !list_more;

    assign s_axis_tready = !r_in_valid || in_done;

    // parallel compare against every live cell
    always_comb begin
        for (int k = 0; k < CAPACITY; k++) begin
            lt[k] = (CNT_W'(k) < r_count) && (r_cells[k] < feat_m);
            eq[k] = (CNT_W'(k) < r_count) && (r_cells[k] == feat_m);
        end
    end

    assign found = |eq;

    always_comb begin
        n_cells  = r_cells;
        n_count  = r_count;
        n_status = ST_OK;
        n_member = '0;
        n_last   = 1'b1;
        n_emit   = 1'b1;
        case (r_func)
            FN_ADD: begin
                if (found) begin
                    n_status = ST_PRESENT;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    if (!lt[0]) begin
                        n_cells[0] = feat_m;
                    end
                    for (int k = 1; k < CAPACITY; k++) begin
                        if (!lt[k]) begin
                            n_cells[k] = lt[k-1] ? feat_m : r_cells[k-1];
                        end
                    end
                    n_count = r_count + CNT_W'(1);
                end
            end
            FN_DEL: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!found) begin
                    n_status = ST_ABSENT;
                end else begin
                    for (int k = 0; k < CAPACITY - 1; k++) begin
                        if (!lt[k]) begin
                            n_cells[k] = r_cells[k+1];
                        end
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            FN_LIST: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_member = r_cells[r_idx];
                    n_last   = !list_more;
                end
            end
            default: begin
                n_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (in_done) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_count <= n_count;
                if (list_more) begin
                    r_idx <= r_idx + IDX_W'(1);
                end else begin
                    r_idx <= '0;
                end
            end
            if (proc && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func <= t_func'(s_axis_tuser);
            r_feat <= s_axis_tdata;
        end
        if (proc) begin
            r_cells <= n_cells;
        end
        if (proc && n_emit) begin
            r_out_status <= n_status;
            r_out_count  <= n_count;
            r_out_member <= n_member;
            r_out_last   <= n_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {2'b00, r_out_member, OUT_CNT_W'(r_out_count)};

    `SSID_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY))
    `SSID_ASSERT_NOW(a_list_holds, i_clk, i_rst_n, proc && list_more, !s_axis_tready)
    `SSID_ASSERT_NOW(a_empty_count, i_clk, i_rst_n,
        r_out_valid && (r_out_status == ST_EMPTY), r_out_count == '0)
    `SSID_ASSERT_NEXT(a_count_step, i_clk, i_rst_n, 1'b1,
        (r_count == $past(r_count)) || (r_count == $past(r_count) + CNT_W'(1))
        || (r_count == $past(r_count) - CNT_W'(1)))

endmodule

FILE: tb/sorted_set_checker.sv
// checker for the sorted set core: watches both stream channels, keeps its own
// copy of the member set, predicts every result and compares it field by field
// depends on ssid_pkg
`timescale 1ns / 1ps

module sorted_set_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic [ssid_pkg::IN_TDATA_W-1:0]  i_req_data,   // feature[15:0]
    input  logic [ssid_pkg::IN_TUSER_W-1:0]  i_req_user,   // func[1:0]
    input  logic                             i_rsp_valid,
    input  logic                             i_rsp_ready,
    input  logic [ssid_pkg::OUT_TDATA_W-1:0] i_rsp_data,   // count[5:0], member[21:6], zero pad
    input  logic [ssid_pkg::OUT_TUSER_W-1:0] i_rsp_user,   // status[2:0]
    input  logic                             i_rsp_last,
    output int                               o_fail_count,
    output int                               o_pending
);

    import ssid_pkg::*;

    typedef struct packed {
        t_status                status;
        logic [OUT_CNT_W-1:0]   count;
        logic [FEAT_W-1:0]      member;
        logic                   last;
    } t_set_result;

    logic [FEAT_W-1:0] set_cells [CAPACITY];
    int                set_size = 0;
    t_set_result       predicted_results [$];
    int                mismatch_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic void push_result(t_status st, int cnt, logic [FEAT_W-1:0] mem,
                                        logic lst);
        t_set_result r;
        r.status = st;
        r.count  = OUT_CNT_W'(cnt);
        r.member = mem;
        r.last   = lst;
        predicted_results = {predicted_results, r};
    endfunction

    function automatic void apply_request(t_func fn, logic [FEAT_W-1:0] raw_feat);
        logic [FEAT_W-1:0] feat;
        int                pos;
        feat = raw_feat & FEAT_MASK;
        pos  = 0;
        case (fn)
            FN_ADD: begin
                while (pos < set_size && set_cells[pos] < feat) pos++;
                if (pos < set_size && set_cells[pos] == feat) begin
                    push_result(ST_PRESENT, set_size, '0, 1'b1);
                end else if (set_size >= CAPACITY) begin
                    push_result(ST_FULL, set_size, '0, 1'b1);
                end else begin
                    for (int i = set_size; i > pos; i--) set_cells[i] = set_cells[i-1];
                    set_cells[pos] = feat;
                    set_size++;
                    push_result(ST_OK, set_size, '0, 1'b1);
                end
            end
            FN_DEL: begin
                if (set_size == 0) begin
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    while (pos < set_size && set_cells[pos] != feat) pos++;
                    if (pos >= set_size) begin
                        push_result(ST_ABSENT, set_size, '0, 1'b1);
                    end else begin
                        for (int i = pos; i + 1 < set_size; i++) set_cells[i] = set_cells[i+1];
                        set_size--;
                        push_result(ST_OK, set_size, '0, 1'b1);
                    end
                end
            end
            FN_LIST: begin
                if (set_size == 0) begin
                    push_result(ST_EMPTY, 0, '0, 1'b1);
                end else begin
                    for (int i = 0; i < set_size; i++)
                        push_result(ST_OK, set_size, set_cells[i], i + 1 == set_size);
                end
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        t_set_result want;
        t_set_result got;
        if (!i_rst_n) begin
            set_size = 0;
            predicted_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.status = t_status'(i_rsp_user);
                got.count  = i_rsp_data[OUT_CNT_W-1:0];
                got.member = i_rsp_data[OUT_CNT_W +: FEAT_W];
                got.last   = i_rsp_last;
                if (predicted_results.size() == 0) begin
                    $error("unexpected result: status %0d count %0d member %0h last %0b",
                           got.status, got.count, got.member, got.last);
                    mismatch_total++;
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        mismatch_total++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        mismatch_total++;
                    end
                    if (got.member !== want.member) begin
                        $error("member: expected %0h, got %0h", want.member, got.member);
                        mismatch_total++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        mismatch_total++;
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                apply_request(t_func'(i_req_user), i_req_data[FEAT_W-1:0]);
        end
        o_fail_count <= mismatch_total;
        o_pending    <= predicted_results.size();
    end

endmodule

FILE: tb/tb_sorted_set_insert_delete_core.sv
// testbench top for the sorted set core: directed and random add, delete and list
// requests with random idling on both sides and one long output stall
// depends on ssid_pkg, sorted_set_checker and the core
`timescale 1ns / 1ps

module tb_sorted_set_insert_delete_core;
    import ssid_pkg::*;

    localparam int RANDOM_ITEMS = 440;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 20;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int POOL_SIZE    = 64;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;    // feature[15:0]
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;    // func[1:0]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // count[5:0], member[21:6], zero pad
    logic [OUT_TUSER_W-1:0] m_axis_tuser;         // status[2:0]
    logic                   m_axis_tlast;

    int fail_count;
    int pending;
    int cycle_count = 0;
    bit calm = 1'b0;
    bit hold_output = 1'b0;

    sorted_set_insert_delete_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    sorted_set_checker check_unit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (s_axis_tvalid),
        .i_req_ready  (s_axis_tready),
        .i_req_data   (s_axis_tdata),
        .i_req_user   (s_axis_tuser),
        .i_rsp_valid  (m_axis_tvalid),
        .i_rsp_ready  (m_axis_tready),
        .i_rsp_data   (m_axis_tdata),
        .i_rsp_user   (m_axis_tuser),
        .i_rsp_last   (m_axis_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_req(input t_func fn, input logic [FEAT_W-1:0] feat);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= feat;
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // output side: random ready with one long quiet stretch
    initial begin : sink
        int run;
        forever begin
            if (hold_output) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 12);
                repeat (run) @(posedge i_clk);
                run = pick_gap();
                if (run > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (run) @(posedge i_clk);
                end
            end
        end
    end

    initial begin : stimulus
        logic [FEAT_W-1:0] pool [POOL_SIZE];
        logic [FEAT_W-1:0] feat;
        t_func             fn;
        int                blk;
        int                base;
        int                done_items;
        int                add_pct;
        int                list_pct;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty set, extremes, duplicates, absent deletes, unused selector
        send_req(FN_LIST, 16'h0000);
        send_req(FN_DEL,  16'h1234);
        send_req(FN_ADD,  16'hFFFF);
        send_req(FN_ADD,  16'h0000);
        send_req(FN_ADD,  16'h8000);
        send_req(FN_ADD,  16'h5555);
        send_req(FN_ADD,  16'hAAAA);
        send_req(FN_ADD,  16'h0000);
        send_req(FN_DEL,  16'h1234);
        send_req(FN_LIST, 16'hFFFF);
        send_req(FN_NONE, 16'hFFFF);
        send_req(FN_DEL,  16'hFFFF);
        send_req(FN_DEL,  16'h0000);
        send_req(FN_DEL,  16'h5555);
        send_req(FN_LIST, 16'h0000);
        send_req(FN_NONE, 16'h0000);
        send_req(FN_DEL,  16'h8000);
        send_req(FN_DEL,  16'hAAAA);
        send_req(FN_LIST, 16'h0000);
        send_req(FN_DEL,  16'h0000);

        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_SIZE; i++) pool[i] = FEAT_W'($urandom);

        blk = 0;
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            base = $urandom_range(0, POOL_SIZE - 1);
            case (blk % 5)
                0: begin
                    // fill past capacity, first time under a long output stall
                    if (blk == 0) hold_output = 1'b1;
                    for (int i = 0; i < 40; i++)
                        send_req(FN_ADD, pool[(base + i) % POOL_SIZE]);
                    send_req(FN_LIST, FEAT_W'($urandom));
                    done_items += 41;
                end
                4: begin
                    // drain everything from the pool, then list and delete a random feature
                    for (int i = 0; i < POOL_SIZE; i++)
                        send_req(FN_DEL, pool[(base + i) % POOL_SIZE]);
                    send_req(FN_LIST, FEAT_W'($urandom));
                    send_req(FN_DEL, FEAT_W'($urandom));
                    done_items += POOL_SIZE + 2;
                end
                default: begin
                    add_pct  = (blk % 5 == 1) ? 70 : (blk % 5 == 2) ? 50 : 25;
                    list_pct = (blk % 5 == 2) ? 20 : 8;
                    for (int i = 0; i < 30; i++) begin
                        feat = ($urandom_range(0, 4) == 0) ? FEAT_W'($urandom)
                                                           : pool[$urandom_range(0, 63)];
                        if ($urandom_range(0, 99) < 3)
                            fn = FN_NONE;
                        else if ($urandom_range(0, 99) < list_pct)
                            fn = FN_LIST;
                        else if ($urandom_range(0, 99) < add_pct)
                            fn = FN_ADD;
                        else
                            fn = FN_DEL;
                        send_req(fn, feat);
                        if (fn != FN_NONE) done_items++;
                    end
                end
            endcase
            blk++;
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ssid_pkg.sv
rtl/sorted_set_insert_delete_core.sv
tb/sorted_set_checker.sv
tb/tb_sorted_set_insert_delete_core.sv
